/* rtl/bdq_pkg.sv */
// shared types and codes for the bounded deque with value removal
`default_nettype none

package bdq_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT   = 3'd0,
        CMD_PUSH_BACK    = 3'd1,
        CMD_POP_FRONT    = 3'd2,
        CMD_POP_BACK     = 3'd3,
        CMD_REMOVE_FIRST = 3'd4,
        CMD_REMOVE_ALL   = 3'd5,
        CMD_EXISTS       = 3'd6,
        CMD_CLEAR        = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_FETCH_F,
        S_FETCH_B,
        S_FETCH_W,
        S_DONE
    } state_t;

    typedef struct packed {
        status_t                    status;
        logic                       found;
        logic signed [VALUE_W-1:0]  front_value;
        logic signed [VALUE_W-1:0]  back_value;
        logic [COUNT_OUT_W-1:0]     entry_count;
    } result_t;

endpackage

`default_nettype wire

/* rtl/bounded_deque_with_value_removal_core.sv */
// top level of the bounded deque with value removal, with result register
//
// input channel: in_valid/in_ready carry command and operand_value; one
// transfer per command. output channel: out_valid/out_ready carry status,
// found, front_value, back_value and entry_count; one transfer per command.
// values live in a ring buffer in a single memory with a registered read port.
// push, pop and clear pass from the execute state through the front fetch
// state, then the back fetch states unless the store ends empty, to the done
// state, from which the result moves into the output register. remove first,
// remove all and exists first walk every stored value, one memory read per cycle.
// one command is in flight at a time; the next input transfer can be taken in
// the cycle after the previous result has moved into the output register, so a
// stalled receiver holds one result while a further command executes, after
// which the block waits for out_ready.
// reset clears the count and head pointer and empties the output register; the
// memory itself is not cleared, as only stored slots are ever read.
`default_nettype none

module bounded_deque_with_value_removal_core
    import bdq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [2:0]                   command,
    input  wire logic signed [VALUE_W-1:0]    operand_value,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [1:0]                        status,
    output logic                              found,
    output logic signed [VALUE_W-1:0]         front_value,
    output logic signed [VALUE_W-1:0]         back_value,
    output logic [COUNT_OUT_W-1:0]            entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic signed [VALUE_W-1:0] wr_data;
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic signed [VALUE_W-1:0] rd_data;
    logic                      res_valid;
    logic                      res_ready;
    result_t                   res;
    logic                      out_valid_reg, out_valid_next;
    result_t                   out_reg;

    bdq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bdq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .operand_value (operand_value),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data)
    );

    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_reg.status;
    assign found       = out_reg.found;
    assign front_value = out_reg.front_value;
    assign back_value  = out_reg.back_value;
    assign entry_count = out_reg.entry_count;

endmodule

`default_nettype wire

/* rtl/bdq_ram.sv */
// entry storage: one write port, one registered read port
`default_nettype none

module bdq_ram
    import bdq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [AW-1:0]             wr_addr,
    input  wire logic signed [VALUE_W-1:0] wr_data,
    input  wire logic                      rd_en,
    input  wire logic [AW-1:0]             rd_addr,
    output logic signed [VALUE_W-1:0]      rd_data
);

    logic signed [VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/bdq_ctrl.sv */
// command sequencer: ring pointers, search and compaction walk, end fetch
`default_nettype none

module bdq_ctrl
    import bdq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [2:0]                command,
    input  wire logic signed [VALUE_W-1:0] operand_value,
    output logic                           res_valid,
    input  wire logic                      res_ready,
    output result_t                        res,
    output logic                           wr_en,
    output logic [AW-1:0]                  wr_addr,
    output logic signed [VALUE_W-1:0]      wr_data,
    output logic                           rd_en,
    output logic [AW-1:0]                  rd_addr,
    input  wire logic signed [VALUE_W-1:0] rd_data
);

    state_t                    state_reg, state_next;
    cmd_t                      cmd_reg, cmd_next;
    logic signed [VALUE_W-1:0] operand_reg, operand_next;
    logic [AW-1:0]             head_reg, head_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [CW-1:0]             rd_idx_reg, rd_idx_next;
    logic [CW-1:0]             wr_idx_reg, wr_idx_next;
    logic                      hit_reg, hit_next;
    status_t                   status_reg, status_next;
    logic                      found_reg, found_next;
    logic signed [VALUE_W-1:0] front_reg, front_next;
    logic signed [VALUE_W-1:0] back_reg, back_next;

    logic          full;
    logic          empty;
    logic          match;
    logic          keep;
    logic [CW-1:0] w_new;

    // ring position of logical slot off
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [AW:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + off;
        if (sum >= (AW+1)'(DEPTH))
        begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign match = (rd_data == operand_reg);

    always_comb
    begin
        keep = 1'b1;
        unique case (cmd_reg)
            CMD_REMOVE_FIRST: keep = !(match && !hit_reg);
            CMD_REMOVE_ALL:   keep = !match;
            default:          keep = 1'b1;
        endcase
        w_new = keep ? wr_idx_reg + CW'(1) : wr_idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        operand_reg <= operand_next;
        rd_idx_reg  <= rd_idx_next;
        wr_idx_reg  <= wr_idx_next;
        hit_reg     <= hit_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
        front_reg   <= front_next;
        back_reg    <= back_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        operand_next = operand_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        rd_idx_next  = rd_idx_reg;
        wr_idx_next  = wr_idx_reg;
        hit_next     = hit_reg;
        status_next  = status_reg;
        found_next   = found_reg;
        front_next   = front_reg;
        back_next    = back_reg;
        in_ready     = 1'b0;
        res_valid    = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = operand_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next     = cmd_t'(command);
                    operand_next = operand_value;
                    status_next  = STATUS_OK;
                    found_next   = 1'b0;
                    state_next   = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next  = S_FETCH_F;
                rd_idx_next = CW'(1);
                wr_idx_next = '0;
                hit_next    = 1'b0;
                unique case (cmd_reg)
                    CMD_PUSH_FRONT:
                    begin
                        if (full)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            head_next  = (head_reg == '0) ? AW'(DEPTH - 1)
                                                          : head_reg - AW'(1);
                            wr_en      = 1'b1;
                            wr_addr    = head_next;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    CMD_PUSH_BACK:
                    begin
                        if (full)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = phys(head_reg, (AW+1)'(count_reg));
                            count_next = count_reg + CW'(1);
                        end
                    end
                    CMD_POP_FRONT:
                    begin
                        if (empty)
                        begin
                            status_next = STATUS_EMPTY;
                        end
                        else
                        begin
                            head_next  = phys(head_reg, (AW+1)'(1));
                            count_next = count_reg - CW'(1);
                        end
                    end
                    CMD_POP_BACK:
                    begin
                        if (empty)
                        begin
                            status_next = STATUS_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                    CMD_REMOVE_FIRST, CMD_REMOVE_ALL:
                    begin
                        if (empty)
                        begin
                            status_next = STATUS_NOT_FOUND;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = head_reg;
                            state_next = S_WALK;
                        end
                    end
                    CMD_EXISTS:
                    begin
                        if (!empty)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = head_reg;
                            state_next = S_WALK;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        count_next = '0;
                    end
                endcase
            end

            S_WALK:
            begin
                // rd_data holds slot rd_idx_reg - 1
                if (rd_idx_reg != count_reg)
                begin
                    rd_en       = 1'b1;
                    rd_addr     = phys(head_reg, (AW+1)'(rd_idx_reg));
                    rd_idx_next = rd_idx_reg + CW'(1);
                end
                if (cmd_reg != CMD_EXISTS)
                begin
                    wr_en       = keep;
                    wr_addr     = phys(head_reg, (AW+1)'(wr_idx_reg));
                    wr_data     = rd_data;
                    wr_idx_next = w_new;
                end
                if (match)
                begin
                    hit_next = 1'b1;
                end
                if (rd_idx_reg == count_reg)
                begin
                    state_next = S_FETCH_F;
                    if (cmd_reg == CMD_EXISTS)
                    begin
                        found_next = hit_reg || match;
                    end
                    else
                    begin
                        count_next = w_new;
                        if (w_new == count_reg)
                        begin
                            status_next = STATUS_NOT_FOUND;
                        end
                    end
                end
            end

            S_FETCH_F:
            begin
                if (empty)
                begin
                    front_next = '0;
                    back_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = head_reg;
                    state_next = S_FETCH_B;
                end
            end

            S_FETCH_B:
            begin
                rd_en      = 1'b1;
                rd_addr    = phys(head_reg, (AW+1)'(count_reg - CW'(1)));
                front_next = rd_data;
                state_next = S_FETCH_W;
            end

            S_FETCH_W:
            begin
                back_next  = rd_data;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.status      = status_reg;
    assign res.found       = found_reg;
    assign res.front_value = front_reg;
    assign res.back_value  = back_reg;
    assign res.entry_count = COUNT_OUT_W'(count_reg);

endmodule

`default_nettype wire

/* tb/testbench.sv */
// self-checking testbench for the bounded deque with value removal core
`default_nettype none

module testbench;
    import bdq_pkg::*;

    localparam int DEPTH = 16;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    typedef struct {
        cmd_t                      cmd;
        logic signed [VALUE_W-1:0] val;
    } deque_cmd_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [2:0]                   command = CMD_PUSH_FRONT;
    logic signed [VALUE_W-1:0]    operand_value = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [1:0]                   status;
    logic                         found;
    logic signed [VALUE_W-1:0]    front_value;
    logic signed [VALUE_W-1:0]    back_value;
    logic [COUNT_OUT_W-1:0]       entry_count;

    deque_cmd_t                   pending_cmds[$];
    deque_cmd_t                   driven_cmd;
    result_t                      expected_results[$];
    logic signed [VALUE_W-1:0]    model_slots[DEPTH];
    int                           model_len = 0;
    int                           send_idle_pct = 0;
    int                           recv_stall_pct = 0;
    int                           error_count = 0;

    bounded_deque_with_value_removal_core #(
        .DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .operand_value(operand_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .found(found),
        .front_value(front_value),
        .back_value(back_value),
        .entry_count(entry_count)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #10000000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic result_t predict_deque(input cmd_t cmd,
                                              input logic signed [VALUE_W-1:0] val);
        result_t r;
        int      i;
        int      w;
        int      hit_pos;
        r.status = STATUS_OK;
        r.found = 1'b0;
        hit_pos = -1;
        w = 0;
        case (cmd)
            CMD_PUSH_FRONT:
            begin
                if (model_len >= DEPTH)
                    r.status = STATUS_FULL;
                else
                begin
                    for (i = model_len; i > 0; i--)
                        model_slots[i] = model_slots[i-1];
                    model_slots[0] = val;
                    model_len++;
                end
            end
            CMD_PUSH_BACK:
            begin
                if (model_len >= DEPTH)
                    r.status = STATUS_FULL;
                else
                begin
                    model_slots[model_len] = val;
                    model_len++;
                end
            end
            CMD_POP_FRONT:
            begin
                if (model_len == 0)
                    r.status = STATUS_EMPTY;
                else
                begin
                    for (i = 0; i + 1 < model_len; i++)
                        model_slots[i] = model_slots[i+1];
                    model_len--;
                end
            end
            CMD_POP_BACK:
            begin
                if (model_len == 0)
                    r.status = STATUS_EMPTY;
                else
                    model_len--;
            end
            CMD_REMOVE_FIRST:
            begin
                for (i = 0; i < model_len; i++)
                begin
                    if (hit_pos < 0 && model_slots[i] == val)
                        hit_pos = i;
                end
                if (hit_pos < 0)
                    r.status = STATUS_NOT_FOUND;
                else
                begin
                    for (i = hit_pos; i + 1 < model_len; i++)
                        model_slots[i] = model_slots[i+1];
                    model_len--;
                end
            end
            CMD_REMOVE_ALL:
            begin
                for (i = 0; i < model_len; i++)
                begin
                    if (model_slots[i] != val)
                    begin
                        model_slots[w] = model_slots[i];
                        w++;
                    end
                end
                if (w == model_len)
                    r.status = STATUS_NOT_FOUND;
                model_len = w;
            end
            CMD_EXISTS:
            begin
                for (i = 0; i < model_len; i++)
                begin
                    if (model_slots[i] == val)
                        r.found = 1'b1;
                end
            end
            default:
                model_len = 0;
        endcase
        if (model_len == 0)
        begin
            r.front_value = '0;
            r.back_value = '0;
        end
        else
        begin
            r.front_value = model_slots[0];
            r.back_value = model_slots[model_len-1];
        end
        r.entry_count = model_len[COUNT_OUT_W-1:0];
        return r;
    endfunction

    task automatic queue_cmd(input cmd_t cmd, input logic signed [VALUE_W-1:0] val);
        deque_cmd_t c;
        c.cmd = cmd;
        c.val = val;
        pending_cmds.push_back(c);
    endtask

    task automatic wait_for_drain();
        while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // driver: one transfer per command, payload held while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            command <= CMD_PUSH_FRONT;
            operand_value <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results.push_back(predict_deque(driven_cmd.cmd, driven_cmd.val));
            if (!in_valid || in_ready)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    driven_cmd = pending_cmds.pop_front();
                    command <= driven_cmd.cmd;
                    operand_value <= driven_cmd.val;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: compare each result transfer with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : monitor_proc
        result_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no prediction waiting");
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status expected %0d actual %0d", want.status, status);
                        error_count++;
                    end
                    if (found !== want.found)
                    begin
                        $error("found expected %0d actual %0d", want.found, found);
                        error_count++;
                    end
                    if (front_value !== want.front_value)
                    begin
                        $error("front_value expected %0d actual %0d",
                               want.front_value, front_value);
                        error_count++;
                    end
                    if (back_value !== want.back_value)
                    begin
                        $error("back_value expected %0d actual %0d",
                               want.back_value, back_value);
                        error_count++;
                    end
                    if (entry_count !== want.entry_count)
                    begin
                        $error("entry_count expected %0d actual %0d",
                               want.entry_count, entry_count);
                        error_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin : stimulus
        int                        phase;
        int                        n;
        int                        k;
        int                        push_pct;
        int                        r;
        logic signed [VALUE_W-1:0] pool[4];
        logic signed [VALUE_W-1:0] v;
        cmd_t                      pick;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty store, full store and removal corner cases
        queue_cmd(CMD_POP_FRONT, 0);
        queue_cmd(CMD_POP_BACK, 0);
        queue_cmd(CMD_REMOVE_FIRST, 0);
        queue_cmd(CMD_REMOVE_ALL, 0);
        queue_cmd(CMD_EXISTS, 0);
        queue_cmd(CMD_CLEAR, 0);
        queue_cmd(CMD_PUSH_FRONT, VAL_MIN);
        queue_cmd(CMD_PUSH_BACK, VAL_MAX);
        queue_cmd(CMD_EXISTS, -1);
        queue_cmd(CMD_EXISTS, VAL_MIN);
        for (k = 0; k < DEPTH - 2; k++)
            queue_cmd((k % 2) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, (k % 3) ? 5 : -1);
        queue_cmd(CMD_PUSH_FRONT, 7);
        queue_cmd(CMD_PUSH_BACK, 7);
        queue_cmd(CMD_REMOVE_FIRST, 5);
        queue_cmd(CMD_REMOVE_ALL, 5);
        queue_cmd(CMD_REMOVE_ALL, 12345);
        queue_cmd(CMD_REMOVE_FIRST, 12345);
        queue_cmd(CMD_POP_FRONT, 0);
        queue_cmd(CMD_POP_BACK, 0);
        queue_cmd(CMD_CLEAR, 0);

        for (phase = 0; phase < 4; phase++)
        begin
            wait_for_drain();
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 63;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 63;
                end
                default:
                begin
                    send_idle_pct = 13;
                    recv_stall_pct = 13;
                end
            endcase
            pool[0] = $urandom_range(15);
            pool[1] = -$urandom_range(1, 15);
            pool[2] = $urandom;
            pool[3] = $urandom;
            push_pct = 80;
            for (n = 0; n < 470; n++)
            begin
                // alternate fill and drain bursts so both full and empty are reached
                if (n % 24 == 0)
                    push_pct = (push_pct == 80) ? 20 : 80;
                r = $urandom_range(9);
                if (r < 6)
                    v = pool[$urandom_range(3)];
                else if (r == 6)
                begin
                    case ($urandom_range(3))
                        0: v = VAL_MIN;
                        1: v = VAL_MAX;
                        2: v = 0;
                        default: v = -1;
                    endcase
                end
                else
                    v = $urandom;
                if ($urandom_range(99) < push_pct)
                    pick = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
                else
                begin
                    r = $urandom_range(99);
                    if (r < 22)
                        pick = CMD_POP_FRONT;
                    else if (r < 44)
                        pick = CMD_POP_BACK;
                    else if (r < 64)
                        pick = CMD_REMOVE_FIRST;
                    else if (r < 80)
                        pick = CMD_REMOVE_ALL;
                    else if (r < 96)
                        pick = CMD_EXISTS;
                    else
                        pick = CMD_CLEAR;
                end
                queue_cmd(pick, v);
            end
        end

        wait_for_drain();
        repeat (30) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d predicted results never arrived", expected_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
rtl/bdq_pkg.sv
rtl/bdq_ram.sv
rtl/bdq_ctrl.sv
rtl/bounded_deque_with_value_removal_core.sv
tb/testbench.sv
